/* rtl/core/rdd_pkg.sv */
// Shared types and constants for the refault distance detector.
// No dependencies; every other file in rtl/core imports this package.
package rdd_pkg;

  localparam int NODE_BITS     = 2;
  localparam int GROUP_BITS    = 4;
  localparam int TAG_BITS      = 2;
  localparam int WORD_BITS     = 64;
  localparam int HDR_BITS      = TAG_BITS + NODE_BITS + GROUP_BITS;
  localparam int AGE_BITS      = WORD_BITS - HDR_BITS;
  localparam int IDX_BITS      = NODE_BITS + GROUP_BITS;
  localparam int PAIR_COUNT    = 1 << IDX_BITS;
  localparam int ACTIVE_BITS   = 48;
  localparam int BO_BITS       = 6;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 6;

  localparam logic [TAG_BITS-1:0] SHADOW_TAG = TAG_BITS'(2);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_AGE_SHIFT  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GROUP_ACCT = 1'b1;

  // input item modes
  localparam logic [1:0] MODE_EVICT    = 2'd0;
  localparam logic [1:0] MODE_ACTIVATE = 2'd1;
  localparam logic [1:0] MODE_REFAULT  = 2'd2;

  // operations handed from front to back
  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_EVICT   = 2'd1;
  localparam logic [1:0] OP_BUMP    = 2'd2;
  localparam logic [1:0] OP_REFAULT = 2'd3;

  typedef struct packed {
    logic [1:0]             mode;
    logic [NODE_BITS-1:0]   node;
    logic [GROUP_BITS-1:0]  group;
    logic                   group_valid;
    logic [WORD_BITS-1:0]   shadow_in;
    logic [ACTIVE_BITS-1:0] active_pages;
  } rdd_in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]  shadow_out;
    logic                  activate;
    logic                  status;
    logic [NODE_BITS-1:0]  decoded_node;
    logic [GROUP_BITS-1:0] decoded_group;
    logic [AGE_BITS-1:0]   distance;
  } rdd_out_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [IDX_BITS-1:0]    idx;
    logic [HDR_BITS-1:0]    hdr;
    logic [NODE_BITS-1:0]   dec_node;
    logic [GROUP_BITS-1:0]  dec_group;
    logic                   status;
    logic [AGE_BITS-1:0]    stored_age;
    logic [ACTIVE_BITS-1:0] active;
  } rdd_cmd_t;

endpackage

/* rtl/core/rdd_front.sv */
// Front end: takes input words and turns them into counter commands.
// Depends on rdd_pkg.
module rdd_front (
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rdd_pkg::rdd_in_t                 in_word,
  input  logic [rdd_pkg::BO_BITS-1:0]      age_shift,
  input  logic                             acct_on,
  input  logic                             q_full,
  output logic                             q_push,
  output rdd_pkg::rdd_cmd_t                q_cmd
);
  import rdd_pkg::*;

  logic [GROUP_BITS-1:0] use_group;
  logic [NODE_BITS-1:0]  sh_node;
  logic [GROUP_BITS-1:0] sh_group;
  logic [AGE_BITS-1:0]   sh_age;
  logic                  missing;

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign use_group = acct_on ? in_word.group : '0;
  assign missing   = acct_on && !in_word.group_valid;
  assign sh_node   = in_word.shadow_in[TAG_BITS +: NODE_BITS];
  assign sh_group  = in_word.shadow_in[TAG_BITS+NODE_BITS +: GROUP_BITS];
  // stored age moved back up by the bucket order; only the low age bits matter
  assign sh_age    = in_word.shadow_in[WORD_BITS-1:HDR_BITS] << age_shift;

  always_comb begin
    q_cmd        = '0;
    q_cmd.active = in_word.active_pages;
    unique case (in_word.mode)
      MODE_EVICT: begin
        q_cmd.op  = OP_EVICT;
        q_cmd.idx = {use_group, in_word.node};
        q_cmd.hdr = {use_group, in_word.node, SHADOW_TAG};
      end
      MODE_ACTIVATE: begin
        q_cmd.op     = missing ? OP_NONE : OP_BUMP;
        q_cmd.status = missing;
        q_cmd.idx    = {use_group, in_word.node};
      end
      MODE_REFAULT: begin
        q_cmd.op         = missing ? OP_NONE : OP_REFAULT;
        q_cmd.status     = missing;
        q_cmd.dec_node   = sh_node;
        q_cmd.dec_group  = sh_group;
        q_cmd.idx        = {(acct_on ? sh_group : {GROUP_BITS{1'b0}}), sh_node};
        q_cmd.stored_age = sh_age;
      end
      default: begin
        q_cmd.op = OP_NONE;
      end
    endcase
  end

endmodule

/* rtl/core/rdd_queue.sv */
// Short command queue between front and back ends.
// Depends on rdd_pkg.
module rdd_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rdd_pkg::rdd_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output rdd_pkg::rdd_cmd_t head_cmd
);
  import rdd_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

  rdd_cmd_t            slot_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_BITS'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/core/rdd_back.sv */
// Back end: age counter memory, read-modify-write sequencer and result register.
// Depends on rdd_pkg.
module rdd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rdd_pkg::BO_BITS-1:0] age_shift,
  input  logic                        q_empty,
  input  rdd_pkg::rdd_cmd_t           q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rdd_pkg::rdd_out_t           out_word
);
  import rdd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_r, state_nxt;
  rdd_cmd_t              cmd_r;
  logic [AGE_BITS-1:0]   age_mem [PAIR_COUNT];
  logic [AGE_BITS-1:0]   rd_data_r;
  logic                  rd_vld_r;
  logic [PAIR_COUNT-1:0] vld_r;
  logic                  out_valid_r, out_valid_nxt;
  rdd_out_t              out_word_r;
  rdd_out_t              res;
  logic [AGE_BITS-1:0]   cur_age, new_age, ref_dist;
  logic                  out_free, finish, wr_en;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign finish    = (state_r == ST_EXEC) && out_free;
  assign wr_en     = finish && (cmd_r.op == OP_EVICT || cmd_r.op == OP_BUMP);

  // entries never written read as zero
  assign cur_age  = rd_vld_r ? rd_data_r : '0;
  assign new_age  = cur_age + 1'b1;
  assign ref_dist = cur_age - cmd_r.stored_age;

  always_comb begin
    res               = '0;
    res.status        = cmd_r.status;
    res.decoded_node  = cmd_r.dec_node;
    res.decoded_group = cmd_r.dec_group;
    case (cmd_r.op)
      OP_EVICT: begin
        res.shadow_out = {new_age >> age_shift, cmd_r.hdr};
      end
      OP_REFAULT: begin
        res.distance = ref_dist;
        res.activate = (ref_dist <= {{(AGE_BITS-ACTIVE_BITS){1'b0}}, cmd_r.active});
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_EXEC;
      ST_EXEC: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        vld_r[cmd_r.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r     <= q_head;
      rd_data_r <= age_mem[q_head.idx];
      rd_vld_r  <= vld_r[q_head.idx];
    end
    if (wr_en) begin
      age_mem[cmd_r.idx] <= new_age;
    end
    if (finish) begin
      out_word_r <= res;
    end
  end

endmodule

/* rtl/core/refault_distance_detector.sv */
// Refault distance detector top level: config registers, front end, queue, back end.
// Depends on rdd_pkg, rdd_front, rdd_queue and rdd_back.
//
// The back end reads a popped word's node/group age counter from its 64-entry memory,
// then, once the output is free, updates it and loads the result register; it pops a
// new word only after finishing the last one. The front end classifies a word in the
// cycle it arrives and parks it in a QUEUE_DEPTH command queue, so the input side keeps
// taking words while a result is stalled, until the queue fills. Counters read as zero
// after reset through per-entry valid bits, so there is no clearing pass.
// Configuration may only be written while the block holds no word in flight.
module refault_distance_detector #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rdd_pkg::rdd_in_t                  in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rdd_pkg::rdd_out_t                 out_word,
  input  logic                              cfg_wr_en,
  input  logic [rdd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rdd_pkg::CFG_DATA_BITS-1:0] cfg_wr_data
);
  import rdd_pkg::*;

  logic [BO_BITS-1:0] age_shift_r;
  logic               acct_on_r;
  logic               q_push, q_pop, q_full, q_empty;
  rdd_cmd_t           push_cmd, head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_shift_r <= '0;
      acct_on_r   <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_AGE_SHIFT:  age_shift_r <= cfg_wr_data[BO_BITS-1:0];
        CFG_GROUP_ACCT: acct_on_r   <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  rdd_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .age_shift (age_shift_r),
    .acct_on   (acct_on_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  rdd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  rdd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .age_shift (age_shift_r),
    .q_empty   (q_empty),
    .q_head    (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid straight after reset");

  a_activate_handled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.activate |-> !out_word.status && out_word.shadow_out == '0)
    else $error("activate raised on an ignored or eviction word");

  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status |-> out_word.distance == '0 && out_word.shadow_out == '0)
    else $error("ignored word carries a distance or shadow");

  a_shadow_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.shadow_out != '0 |-> out_word.shadow_out[TAG_BITS-1:0] == SHADOW_TAG)
    else $error("shadow word without its tag");

endmodule
